@@ src/dlr_pkg.sv @@
package dlr_pkg;

    localparam int COORD_BITS = 10;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last;
    } out_item_t;

endpackage

@@ src/dda_line_rasterizer.sv @@
// DDA line rasterizer.
// Input channel s_*: a load beat (opcode OP_LOAD) sets up a line from the
// start point to the end point; a step beat (opcode OP_STEP) asks for the
// next pixel. Output channel m_*: one beat per pixel, last marking the final
// pixel of the line. The start point is never sent; a line gives
// max(|dx|, |dy|) pixels, and a step beat with no pixels left gives nothing.
// A step beat is taken and its pixel appears on m_* at the next
// edge; steps stream at one per cycle while the receiver keeps up.
// A load beat runs one shared restoring divider, one quotient bit per cycle,
// first for the x increment and then for y: the block is busy while it
// divides after the load, and s_ready stays low meanwhile.
// A zero-length load leaves the block ready at once.
// s_ready is also low while a pixel waits in the output register and m_ready
// is low, so a stalled receiver holds the block without losing a beat.
// Reset clears the line state: steps before the first load give nothing.
module dda_line_rasterizer #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dlr_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output dlr_pkg::out_item_t m_payload
);
    import dlr_pkg::*;

    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int REM_W  = COORD_BITS + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } state_t;

    state_t                 state_reg, state_next;
    logic [ACC_W-1:0]       acc_x_reg, acc_x_next;
    logic [ACC_W-1:0]       acc_y_reg, acc_y_next;
    logic [STEP_W-1:0]      step_x_reg, step_x_next;
    logic [STEP_W-1:0]      step_y_reg, step_y_next;
    logic [COORD_BITS:0]    pixels_left_reg, pixels_left_next;
    logic [COORD_BITS-1:0]  len_reg, len_next;
    logic [COORD_BITS-1:0]  mag_y_reg, mag_y_next;
    logic                   neg_x_reg, neg_x_next;
    logic                   neg_y_reg, neg_y_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [Q_W-1:0]         quot_reg, quot_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_payload_reg, m_payload_next;

    logic                   in_beat;
    logic [COORD_BITS:0]    dx, dy;
    logic [COORD_BITS-1:0]  ax, ay, len;
    logic [REM_W-1:0]       diff;
    logic                   lt;
    logic [REM_W-1:0]       rem_kept;
    logic [Q_W-1:0]         quot_shift;
    logic [STEP_W-1:0]      q_ext, q_signed;
    logic                   q_neg;
    logic [ACC_W-1:0]       acc_x_sum, acc_y_sum;

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_beat   = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign dx  = {1'b0, s_payload.end_x} - {1'b0, s_payload.start_x};
    assign dy  = {1'b0, s_payload.end_y} - {1'b0, s_payload.start_y};
    assign ax  = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ay  = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    assign len = (ax >= ay) ? ax : ay;

    // shared divider: compare, restore, shift
    assign diff       = rem_reg - {1'b0, len_reg};
    assign lt         = rem_reg < {1'b0, len_reg};
    assign rem_kept   = lt ? rem_reg : diff;
    assign quot_shift = {quot_reg[Q_W-2:0], ~lt};
    assign q_neg      = (state_reg == ST_DIV_X) ? neg_x_reg : neg_y_reg;
    assign q_ext      = {1'b0, quot_shift};
    assign q_signed   = q_neg ? -q_ext : q_ext;

    assign acc_x_sum = acc_x_reg + {{(ACC_W-STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
    assign acc_y_sum = acc_y_reg + {{(ACC_W-STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};

    always_comb begin
        state_next       = state_reg;
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        pixels_left_next = pixels_left_reg;
        len_next         = len_reg;
        mag_y_next       = mag_y_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_payload_next   = m_payload_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_payload.opcode == OP_LOAD) begin
                        acc_x_next       = {1'b0, s_payload.start_x, FRAC_BITS'(0)};
                        acc_y_next       = {1'b0, s_payload.start_y, FRAC_BITS'(0)};
                        pixels_left_next = {1'b0, len};
                        len_next         = len;
                        mag_y_next       = ay;
                        neg_x_next       = dx[COORD_BITS];
                        neg_y_next       = dy[COORD_BITS];
                        rem_next         = {1'b0, ax};
                        quot_next        = '0;
                        cnt_next         = CNT_W'(FRAC_BITS);
                        if (len == '0) begin
                            step_x_next = '0;
                            step_y_next = '0;
                        end else begin
                            state_next = ST_DIV_X;
                        end
                    end else if (pixels_left_reg != '0) begin
                        acc_x_next             = acc_x_sum;
                        acc_y_next             = acc_y_sum;
                        pixels_left_next       = pixels_left_reg - 1'b1;
                        m_valid_next           = 1'b1;
                        m_payload_next.pixel_x = acc_x_sum[FRAC_BITS +: COORD_BITS];
                        m_payload_next.pixel_y = acc_y_sum[FRAC_BITS +: COORD_BITS];
                        m_payload_next.last    = (pixels_left_reg == (COORD_BITS+1)'(1));
                    end
                end
            end
            ST_DIV_X, ST_DIV_Y: begin
                rem_next  = {rem_kept[REM_W-2:0], 1'b0};
                quot_next = quot_shift;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if (state_reg == ST_DIV_X) begin
                        step_x_next = q_signed;
                        rem_next    = {1'b0, mag_y_reg};
                        quot_next   = '0;
                        cnt_next    = CNT_W'(FRAC_BITS);
                        state_next  = ST_DIV_Y;
                    end else begin
                        step_y_next = q_signed;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            step_x_reg      <= '0;
            step_y_reg      <= '0;
            pixels_left_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            acc_x_reg       <= acc_x_next;
            acc_y_reg       <= acc_y_next;
            step_x_reg      <= step_x_next;
            step_y_reg      <= step_y_next;
            pixels_left_reg <= pixels_left_next;
            m_valid_reg     <= m_valid_next;
        end
        len_reg       <= len_next;
        mag_y_reg     <= mag_y_next;
        neg_x_reg     <= neg_x_next;
        neg_y_reg     <= neg_y_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        cnt_reg       <= cnt_next;
        m_payload_reg <= m_payload_next;
    end

    a_no_pixel_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> !$rose(m_valid_reg))
        else $error("pixel beat raised during divide");

    a_final_pixel_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_payload.opcode == OP_STEP && pixels_left_reg == (COORD_BITS+1)'(1))
        |=> (m_valid_reg && m_payload_reg.last && pixels_left_reg == '0))
        else $error("final pixel not marked or count not cleared");

    a_count_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_payload.opcode == OP_STEP && pixels_left_reg != '0)
        |=> (pixels_left_reg == $past(pixels_left_reg) - 1'b1))
        else $error("pixel count did not advance");

    a_load_starts_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_payload.opcode == OP_LOAD && len != '0) |=> (state_reg == ST_DIV_X))
        else $error("non-empty load did not start the divider");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import dlr_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int ACC_W        = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_W        = FRAC_BITS + 2;
    localparam int LEFT_W       = COORD_BITS + 1;
    localparam int LOAD_CYCLES  = 2 * (FRAC_BITS + 1);
    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 1500000;

    class line_scoreboard;
        logic signed [ACC_W-1:0] acc_x, acc_y;
        logic signed [INC_W-1:0] inc_x, inc_y;
        logic [LEFT_W-1:0]       pixels_left;
        out_item_t               pending_pixels[$];
        int                      errors;
        int                      loads;
        int                      pixels_checked;
        int                      lines_finished;

        function longint fixed_increment(longint d, longint len);
            longint mag, q;
            mag = (d < 0) ? -d : d;
            q   = (mag << FRAC_BITS) / len;
            return (d < 0) ? -q : q;
        endfunction

        function logic [COORD_BITS-1:0] whole_part(longint a);
            longint v;
            if (a < 0) begin
                v = -((-a) >> FRAC_BITS);
            end else begin
                v = a >> FRAC_BITS;
            end
            return v[COORD_BITS-1:0];
        endfunction

        function void note_beat(in_item_t b);
            longint    dx, dy, ax, ay, len;
            out_item_t px;
            if (b.opcode == OP_LOAD) begin
                dx = longint'(b.end_x) - longint'(b.start_x);
                dy = longint'(b.end_y) - longint'(b.start_y);
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                len = (ax >= ay) ? ax : ay;
                acc_x = ACC_W'(longint'(b.start_x) << FRAC_BITS);
                acc_y = ACC_W'(longint'(b.start_y) << FRAC_BITS);
                pixels_left = len[LEFT_W-1:0];
                if (len == 0) begin
                    inc_x = '0;
                    inc_y = '0;
                end else begin
                    inc_x = INC_W'(fixed_increment(dx, len));
                    inc_y = INC_W'(fixed_increment(dy, len));
                end
                loads++;
            end else if (pixels_left != 0) begin
                acc_x = acc_x + inc_x;
                acc_y = acc_y + inc_y;
                px.pixel_x = whole_part(longint'(acc_x));
                px.pixel_y = whole_part(longint'(acc_y));
                px.last    = (pixels_left == 1);
                pixels_left--;
                pending_pixels.push_back(px);
            end
        endfunction

        function void check_pixel(out_item_t p);
            out_item_t e;
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d last=%0d", p.pixel_x, p.pixel_y, p.last);
                errors++;
                return;
            end
            e = pending_pixels.pop_front();
            pixels_checked++;
            if (p.last) lines_finished++;
            if (p.pixel_x !== e.pixel_x) begin
                $error("pixel_x: expected %0d, got %0d", e.pixel_x, p.pixel_x);
                errors++;
            end
            if (p.pixel_y !== e.pixel_y) begin
                $error("pixel_y: expected %0d, got %0d", e.pixel_y, p.pixel_y);
                errors++;
            end
            if (p.last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, p.last);
                errors++;
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_payload;

    line_scoreboard sb;
    bit             gaps_on = 1'b1;
    int             ready_run = 0;
    int             cycle_count = 0;

    dda_line_rasterizer #(
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
        if (v < 0) return '0;
        if (v > (1 << COORD_BITS) - 1) return '1;
        return v[COORD_BITS-1:0];
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_beat(s_payload);
        if (aresetn && m_valid && m_ready) sb.check_pixel(m_payload);
    end

    // hold m_ready low for short or long stalls, high for short or long runs
    always @(posedge aclk) begin
        if (ready_run > 0) begin
            ready_run--;
        end else if (m_ready) begin
            m_ready <= 1'b0;
            ready_run = pick_gap();
        end else begin
            m_ready <= 1'b1;
            ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(0, 12);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_beat(input in_item_t item);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_payload <= item;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic load_line(input logic [COORD_BITS-1:0] x0, y0, x1, y1);
        in_item_t item;
        item.opcode  = OP_LOAD;
        item.start_x = x0;
        item.start_y = y0;
        item.end_x   = x1;
        item.end_y   = y1;
        send_beat(item);
    endtask

    // coordinates of a step beat are ignored, so fill them with noise
    task automatic step_line(input int n);
        in_item_t item;
        repeat (n) begin
            item.opcode  = OP_STEP;
            item.start_x = COORD_BITS'($urandom);
            item.start_y = COORD_BITS'($urandom);
            item.end_x   = COORD_BITS'($urandom);
            item.end_y   = COORD_BITS'($urandom);
            send_beat(item);
        end
    endtask

    initial begin
        logic [COORD_BITS-1:0] x0, y0, x1, y1;
        int kind, len, nsteps, useful, ax, ay, sx, sy;

        sb = new;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        step_line(1);
        load_line(0, 0, 0, 0);
        step_line(1);
        load_line(0, 0, 1023, 1023);
        step_line(3);
        load_line(1023, 1023, 0, 0);
        step_line(3);
        load_line(1023, 0, 0, 1023);
        step_line(2);
        load_line(5, 5, 7, 4);
        step_line(3);
        load_line(1023, 1023, 1023, 1023);
        step_line(1);

        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0) step_line($urandom_range(1, 4));
            kind = $urandom_range(0, 99);
            x0 = COORD_BITS'($urandom);
            y0 = COORD_BITS'($urandom);
            if (kind < 60) begin
                x1 = clamp_coord(int'(x0) + int'($urandom_range(0, 32)) - 16);
                y1 = clamp_coord(int'(y0) + int'($urandom_range(0, 32)) - 16);
            end else if (kind < 80) begin
                len = $urandom_range(1, 24);
                sx = $urandom_range(0, 1) ? len : -len;
                sy = $urandom_range(0, 1) ? len : -len;
                case ($urandom_range(0, 2))
                    0: sy = 0;
                    1: sx = 0;
                    default: ;
                endcase
                x1 = clamp_coord(int'(x0) + sx);
                y1 = clamp_coord(int'(y0) + sy);
            end else begin
                x1 = COORD_BITS'($urandom);
                y1 = COORD_BITS'($urandom);
            end
            ax = (x1 > x0) ? int'(x1 - x0) : int'(x0 - x1);
            ay = (y1 > y0) ? int'(y1 - y0) : int'(y0 - y1);
            len = (ax >= ay) ? ax : ay;
            load_line(x0, y0, x1, y1);
            if (kind >= 80 && !(kind >= 98 && useful + len < RANDOM_ITEMS)) begin
                nsteps = $urandom_range(0, 30);
            end else if ($urandom_range(0, 9) == 0) begin
                nsteps = $urandom_range(0, len);
            end else begin
                nsteps = len + $urandom_range(0, 2);
            end
            step_line(nsteps);
            useful += 1 + ((nsteps < len) ? nsteps : len);
        end

        s_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (LOAD_CYCLES + 8) @(posedge aclk);

        $display("%0d line loads, %0d pixels checked, %0d lines drawn to their last pixel",
                 sb.loads, sb.pixels_checked, sb.lines_finished);
        $display("covered zero-length and edge-to-edge lines, mid-line reloads, steps past the end");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
